// File: rtl/gqtl_pkg.sv
// Package for the glyph quad text layout block: defaults, register and vertex codes, helpers.
`default_nettype none

package gqtl_pkg;

    // Default sizes for the top-level parameters
    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int TEX_COORD_BITS_DEF = 12;

    // Fixed field widths of the streams
    localparam int CODE_W   = 8;
    localparam int TEX_IN_W = 12;
    localparam int TEX_OUT_W = 13;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 96;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WIDTH   = 8'd0,
        CFG_WRAP_EN     = 8'd1,
        CFG_LINE_STEP   = 8'd2,
        CFG_BASE_HEIGHT = 8'd3
    } t_cfg_idx;

    // Vertex order within one glyph quad
    typedef enum logic [2:0] {
        VTX_LL  = 3'd0,
        VTX_UL  = 3'd1,
        VTX_LR  = 3'd2,
        VTX_UR  = 3'd3,
        VTX_UL2 = 3'd4,
        VTX_LR2 = 3'd5
    } t_vtx;

    // Saturate a 17-bit unsigned sum to 16 bits
    function automatic logic [15:0] sat_u16(input logic [16:0] v);
        sat_u16 = v[16] ? 16'hFFFF : v[15:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/glyph_quad_text_layout_core.sv
// Top level of the glyph quad text layout block.
//
// Input stream (s_axis): tuser carries mode, 0 loads a glyph table entry and 1
// places a character. A load is written to the glyph table at its accepting
// edge, gives no output, and loads are taken every cycle that tready is high.
// A place item reads the glyph table (one synchronous port), then a
// layout stage applies first_char, the wrap test and the pen update and fills
// the vertex register bank. The bank sends six vertex beats LL, UL, LR, UR,
// UL, LR on m_axis, tlast on the sixth.
// The place item is registered in the read stage, then enters the vertex
// register bank once the bank is free; the bank sends one vertex beat per
// cycle while m_axis_tready is high. The next item is read from the table
// while the single vertex output register bank still sends the current quad.
// Configuration (cfg): always ready; write only while the block is idle.
// Reset: pen and text height clear, registers take their reset values; the
// glyph table is not cleared and must be loaded before use.
// Stall: when m_axis_tready is low the current vertex holds; one place item
// waits in the read stage, after which s_axis_tready drops.
`default_nettype none

module glyph_quad_text_layout_core
    import gqtl_pkg::*;
#(
    parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
    parameter int TEX_COORD_BITS = TEX_COORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [7:0] char_code, [8] first_char, [16:9] glyph_advance, [28:17] glyph_tex_x,
    // [40:29] glyph_tex_y, [48:41] glyph_w, [56:49] glyph_h, [63:57] zero
    input  wire logic [S_DATA_W-1:0]  i_s_axis_tdata,
    // [0] mode
    input  wire logic                 i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [44:32] tex_u, [57:45] tex_v,
    // [73:58] line_width, [89:74] text_height, [95:90] zero
    output logic      [M_DATA_W-1:0]  o_m_axis_tdata,
    output logic                      o_m_axis_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int TW = TEX_COORD_BITS;
    localparam int SW = TW + 1;
    localparam int TEX_SAT_I = (SW > TEX_OUT_W) ? ((1 << TEX_OUT_W) - 1) : ((1 << SW) - 1);
    localparam logic [SW-1:0] TEX_SAT = SW'(TEX_SAT_I);

    // Configuration registers
    logic [15:0] r_max_width;
    logic        r_wrap_en;
    logic [7:0]  r_line_step;
    logic [7:0]  r_base_height;

    // Layout state
    logic [15:0]        r_pen_x;
    logic signed [15:0] r_pen_y;
    logic [15:0]        r_height;

    // Read stage
    logic r_s1_valid;
    logic r_s1_first;

    // Vertex register bank
    logic                 r_vb_valid;
    t_vtx                 r_vtx;
    logic [15:0]          r_x0, r_x1;
    logic signed [15:0]   r_y0, r_y1;
    logic [TEX_OUT_W-1:0] r_u0, r_u1, r_v0, r_v1;
    logic [15:0]          r_lw, r_th;

    // Glyph from the table
    logic [7:0]    g_adv, g_w, g_h;
    logic [TW-1:0] g_tx, g_ty;

    // Handshake
    logic in_acc, place_acc, load_acc, beat, vb_done, vb_free, s1_adv;

    // Layout datapath
    logic [15:0]        px, ha, px2, ha2;
    logic signed [15:0] py, py2, y1;
    logic [16:0]        wrap_sum, x1_sum, adv_sum, ha_sum;
    logic signed [16:0] y_sub, y1_sum;
    logic               wrap;
    logic [SW-1:0]      u1_sum, v1_sum;
    logic [15:0]        n_pen_x;
    logic               sel_x1, sel_y1;

    function automatic logic [TEX_OUT_W-1:0] sat_tex(input logic [SW-1:0] v);
        sat_tex = (v > TEX_SAT) ? TEX_OUT_W'(TEX_SAT) : TEX_OUT_W'(v);
    endfunction

    // Handshakes
    assign o_cfg_ready     = 1'b1;
    assign beat            = r_vb_valid && i_m_axis_tready;
    assign vb_done         = beat && (r_vtx == VTX_LR2);
    assign vb_free         = !r_vb_valid || vb_done;
    assign s1_adv          = r_s1_valid && vb_free;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign place_acc       = in_acc && i_s_axis_tuser;
    assign load_acc        = in_acc && !i_s_axis_tuser;

    gqtl_glyph_mem #(
        .GLYPH_COUNT    (GLYPH_COUNT),
        .TEX_COORD_BITS (TEX_COORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr_en (load_acc),
        .i_rd_en (place_acc),
        .i_code  (i_s_axis_tdata[7:0]),
        .i_adv   (i_s_axis_tdata[16:9]),
        .i_tex_x (i_s_axis_tdata[28:17]),
        .i_tex_y (i_s_axis_tdata[40:29]),
        .i_w     (i_s_axis_tdata[48:41]),
        .i_h     (i_s_axis_tdata[56:49]),
        .o_adv   (g_adv),
        .o_tex_x (g_tx),
        .o_tex_y (g_ty),
        .o_w     (g_w),
        .o_h     (g_h)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width   <= 16'hFFFF;
            r_wrap_en     <= 1'b0;
            r_line_step   <= 8'd0;
            r_base_height <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_WIDTH:   r_max_width   <= i_cfg_data;
                CFG_WRAP_EN:     r_wrap_en     <= i_cfg_data[0];
                CFG_LINE_STEP:   r_line_step   <= i_cfg_data[7:0];
                CFG_BASE_HEIGHT: r_base_height <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Apply first_char and the wrap test, then build the quad
    always_comb begin
        px = r_s1_first ? 16'd0 : r_pen_x;
        py = r_s1_first ? 16'sd0 : r_pen_y;
        ha = r_s1_first ? {8'd0, r_base_height} : r_height;

        wrap_sum = {1'b0, px} + {9'd0, g_adv};
        wrap     = r_wrap_en && (wrap_sum > {1'b0, r_max_width});

        y_sub  = {py[15], py} - $signed({9'd0, r_line_step});
        ha_sum = {1'b0, ha} + {9'd0, r_line_step};
        px2    = wrap ? 16'd0 : px;
        py2    = py;
        ha2    = ha;
        if (wrap) begin
            py2 = (y_sub[16] != y_sub[15]) ? -16'sd32768 : y_sub[15:0];
            ha2 = sat_u16(ha_sum);
        end

        x1_sum  = {1'b0, px2} + {9'd0, g_w};
        adv_sum = {1'b0, px2} + {9'd0, g_adv};
        y1_sum  = {py2[15], py2} + $signed({9'd0, g_h});
        y1      = (y1_sum[16] != y1_sum[15]) ? 16'sd32767 : y1_sum[15:0];
        u1_sum  = SW'(g_tx) + SW'(g_w);
        v1_sum  = SW'(g_ty) + SW'(g_h);
        n_pen_x = sat_u16(adv_sum);
    end

    // Advance pen state when a placed glyph enters the vertex bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= 16'd0;
            r_pen_y  <= 16'sd0;
            r_height <= 16'd0;
        end else if (s1_adv) begin
            r_pen_x  <= n_pen_x;
            r_pen_y  <= py2;
            r_height <= ha2;
        end
    end

    // Hold a place item while the table read completes and until the bank takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (place_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (place_acc) begin
            r_s1_first <= i_s_axis_tdata[8];
        end
    end

    // Vertex bank control: load a quad, step through six beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb_valid <= 1'b0;
            r_vtx      <= VTX_LL;
        end else if (s1_adv) begin
            r_vb_valid <= 1'b1;
            r_vtx      <= VTX_LL;
        end else if (vb_done) begin
            r_vb_valid <= 1'b0;
        end else if (beat) begin
            r_vtx <= t_vtx'(r_vtx + 3'd1);
        end
    end

    // Vertex bank payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_x0 <= px2;
            r_x1 <= sat_u16(x1_sum);
            r_y0 <= py2;
            r_y1 <= y1;
            r_u0 <= sat_tex(SW'(g_tx));
            r_u1 <= sat_tex(u1_sum);
            r_v0 <= sat_tex(SW'(g_ty));
            r_v1 <= sat_tex(v1_sum);
            r_lw <= n_pen_x;
            r_th <= ha2;
        end
    end

    // Pick corner of the current vertex
    always_comb begin
        unique case (r_vtx)
            VTX_LL:  begin sel_x1 = 1'b0; sel_y1 = 1'b0; end
            VTX_UL:  begin sel_x1 = 1'b0; sel_y1 = 1'b1; end
            VTX_LR:  begin sel_x1 = 1'b1; sel_y1 = 1'b0; end
            VTX_UR:  begin sel_x1 = 1'b1; sel_y1 = 1'b1; end
            VTX_UL2: begin sel_x1 = 1'b0; sel_y1 = 1'b1; end
            VTX_LR2: begin sel_x1 = 1'b1; sel_y1 = 1'b0; end
            default: begin sel_x1 = 1'b0; sel_y1 = 1'b0; end
        endcase
    end

    assign o_m_axis_tvalid = r_vb_valid;
    assign o_m_axis_tlast  = (r_vtx == VTX_LR2);
    assign o_m_axis_tdata  = {6'd0,
                              r_th,
                              r_lw,
                              sel_y1 ? r_v0 : r_v1,
                              sel_x1 ? r_u1 : r_u0,
                              sel_y1 ? r_y1 : r_y0,
                              sel_x1 ? r_x1 : r_x0};

endmodule

`default_nettype wire

// File: rtl/gqtl_glyph_mem.sv
// Glyph table memory: one write or one registered read per cycle, zero glyph beyond the table.
`default_nettype none

module gqtl_glyph_mem
    import gqtl_pkg::*;
#(
    parameter int GLYPH_COUNT    = GLYPH_COUNT_DEF,
    parameter int TEX_COORD_BITS = TEX_COORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_wr_en,
    input  wire logic                      i_rd_en,
    input  wire logic [CODE_W-1:0]         i_code,
    input  wire logic [7:0]                i_adv,
    input  wire logic [TEX_IN_W-1:0]       i_tex_x,
    input  wire logic [TEX_IN_W-1:0]       i_tex_y,
    input  wire logic [7:0]                i_w,
    input  wire logic [7:0]                i_h,
    output logic      [7:0]                o_adv,
    output logic      [TEX_COORD_BITS-1:0] o_tex_x,
    output logic      [TEX_COORD_BITS-1:0] o_tex_y,
    output logic      [7:0]                o_w,
    output logic      [7:0]                o_h
);

    localparam int TW = TEX_COORD_BITS;
    localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int EW = 8 + TW + TW + 8 + 8;

    logic [EW-1:0] r_mem [GLYPH_COUNT];
    logic [EW-1:0] r_rd_data;
    logic          r_rd_hit;
    logic          in_range;
    logic [AW-1:0] addr;
    logic [EW-1:0] wr_entry;

    // Decode the table index
    assign in_range = ({1'b0, i_code} < (CODE_W+1)'(GLYPH_COUNT));
    assign addr     = i_code[AW-1:0];
    assign wr_entry = {i_h, i_w, TW'(i_tex_y), TW'(i_tex_x), i_adv};

    // Write on load, read on place
    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            r_mem[addr] <= wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[addr];
            r_rd_hit  <= in_range;
        end
    end

    // Unpack, forcing a zero glyph for codes beyond the table
    always_comb begin
        if (r_rd_hit) begin
            {o_h, o_w, o_tex_y, o_tex_x, o_adv} = r_rd_data;
        end else begin
            {o_h, o_w, o_tex_y, o_tex_x, o_adv} = '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gqtl_checker.sv
// Port-level checker for the glyph quad text layout block, bound to the top level.
`default_nettype none

module gqtl_checker
    import gqtl_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [M_DATA_W-1:0]  o_m_axis_tdata,
    input wire logic                 o_m_axis_tlast
);

    // No vertex beat straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("vertex valid after reset");

    // Hold a stalled vertex beat
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("vertex valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tlast))
        else $error("vertex payload changed while stalled");

    // Line width and text height stay fixed across the beats of one quad
    a_quad_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && (o_m_axis_tdata[89:58] == $past(o_m_axis_tdata[89:58])))
        else $error("quad totals changed inside a quad");

endmodule

bind glyph_quad_text_layout_core gqtl_checker u_gqtl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
